// File: sv/sps_pkg.sv
// shared types and constants for the subpixel stamp mask shift block
package sps_pkg;

    // pen is a 3x3 stamp, blended out of a 4x4 round mask
    localparam int PEN_SPAN   = 2;
    localparam int STAMP_SIZE = PEN_SPAN + 1;
    localparam int MASK_SIZE  = STAMP_SIZE + 1;

    localparam logic [7:0] PEN_MASK [MASK_SIZE][MASK_SIZE] = '{
        '{8'hFF, 8'hE6, 8'hE6, 8'hFF},
        '{8'hE6, 8'h33, 8'h33, 8'hE6},
        '{8'hE6, 8'h33, 8'h33, 8'hE6},
        '{8'hFF, 8'hE6, 8'hE6, 8'hFF}
    };

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LEFT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_TOP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_RIGHT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_BOTTOM  = 3'd4;

    localparam logic [11:0]        RST_FRAME_HEIGHT = 12'd240;
    localparam logic signed [15:0] RST_CLIP_LEFT    = 16'sd0;
    localparam logic signed [15:0] RST_CLIP_TOP     = 16'sd0;
    localparam logic signed [15:0] RST_CLIP_RIGHT   = 16'sd319;
    localparam logic signed [15:0] RST_CLIP_BOTTOM  = 16'sd239;

    typedef struct packed {
        logic [11:0]        frame_height;
        logic signed [15:0] clip_left;
        logic signed [15:0] clip_top;
        logic signed [15:0] clip_right;
        logic signed [15:0] clip_bottom;
    } t_cfg_regs;

    typedef struct packed {
        logic signed [23:0] pen_x;
        logic signed [23:0] pen_y;
    } t_in_word;

    typedef struct packed {
        logic               visible;
        logic signed [15:0] stamp_x;
        logic signed [15:0] stamp_y;
        logic [7:0]         weight_r0c0;
        logic [7:0]         weight_r0c1;
        logic [7:0]         weight_r0c2;
        logic [7:0]         weight_r1c0;
        logic [7:0]         weight_r1c1;
        logic [7:0]         weight_r1c2;
        logic [7:0]         weight_r2c0;
        logic [7:0]         weight_r2c1;
        logic [7:0]         weight_r2c2;
    } t_out_word;

endpackage

// File: sv/sps_front.sv
// first stage: floor and fraction split, vertical drop and clip test
module sps_front #(
    parameter int FRAC_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  sps_pkg::t_in_word     i_word,
    input  sps_pkg::t_cfg_regs    i_cfg,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_keep,
    output logic [15:0]           o_stamp_x,
    output logic [15:0]           o_stamp_y,
    output logic [FRAC_BITS-1:0]  o_fx,
    output logic [FRAC_BITS-1:0]  o_fy
);
    import sps_pkg::*;

    // integer part width and a compare width with headroom for +2
    localparam int PW = 24 - FRAC_BITS;
    localparam int CW = ((PW > 16) ? PW : 16) + 2;

    logic                 r_valid;
    logic                 r_keep;
    logic [15:0]          r_stamp_x;
    logic [15:0]          r_stamp_y;
    logic [FRAC_BITS-1:0] r_fx;
    logic [FRAC_BITS-1:0] r_fy;

    logic                 w_ready;
    logic                 n_keep;
    logic [PW-1:0]        w_px_raw;
    logic [PW-1:0]        w_py_raw;
    logic signed [CW-1:0] w_px;
    logic signed [CW-1:0] w_py;
    logic signed [CW-1:0] w_px2;
    logic signed [CW-1:0] w_py2;
    logic signed [CW-1:0] w_cl;
    logic signed [CW-1:0] w_ct;
    logic signed [CW-1:0] w_cr;
    logic signed [CW-1:0] w_cb;
    logic signed [CW-1:0] w_ymin;
    logic signed [CW-1:0] w_ymax;
    logic                 w_fy_nz;

    assign w_ready = !r_valid || !i_stall;
    assign o_stall = !w_ready;

    // floor is an arithmetic shift, fraction is the low bits
    assign w_px_raw = i_word.pen_x[23:FRAC_BITS];
    assign w_py_raw = i_word.pen_y[23:FRAC_BITS];
    assign w_px     = {{(CW-PW){w_px_raw[PW-1]}}, w_px_raw};
    assign w_py     = {{(CW-PW){w_py_raw[PW-1]}}, w_py_raw};
    assign w_px2    = w_px + CW'(STAMP_SIZE - 1);
    assign w_py2    = w_py + CW'(STAMP_SIZE - 1);
    assign w_fy_nz  = (i_word.pen_y[FRAC_BITS-1:0] != '0);

    assign w_cl = {{(CW-16){i_cfg.clip_left[15]}},   i_cfg.clip_left};
    assign w_ct = {{(CW-16){i_cfg.clip_top[15]}},    i_cfg.clip_top};
    assign w_cr = {{(CW-16){i_cfg.clip_right[15]}},  i_cfg.clip_right};
    assign w_cb = {{(CW-16){i_cfg.clip_bottom[15]}}, i_cfg.clip_bottom};

    // row limits in whole pixels; the upper one is exact only with zero fraction
    assign w_ymin = -CW'(STAMP_SIZE);
    assign w_ymax = {{(CW-12){1'b0}}, i_cfg.frame_height} + CW'(STAMP_SIZE);

    always_comb begin
        n_keep = 1'b1;
        if (w_py < w_ymin) begin
            n_keep = 1'b0;
        end
        if ((w_py > w_ymax) || ((w_py == w_ymax) && w_fy_nz)) begin
            n_keep = 1'b0;
        end
        if ((w_cl > w_cr) || (w_ct > w_cb)) begin
            n_keep = 1'b0;
        end
        if ((w_px > w_cr) || (w_px2 < w_cl) || (w_py > w_cb) || (w_py2 < w_ct)) begin
            n_keep = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready && i_valid) begin
            r_keep    <= n_keep;
            r_stamp_x <= w_px[15:0];
            r_stamp_y <= w_py[15:0];
            r_fx      <= i_word.pen_x[FRAC_BITS-1:0];
            r_fy      <= i_word.pen_y[FRAC_BITS-1:0];
        end
    end

    assign o_valid   = r_valid;
    assign o_keep    = r_keep;
    assign o_stamp_x = r_stamp_x;
    assign o_stamp_y = r_stamp_y;
    assign o_fx      = r_fx;
    assign o_fy      = r_fy;

endmodule

// File: sv/sps_vblend.sv
// second stage: vertical blend of mask rows by the row fraction
module sps_vblend #(
    parameter int FRAC_BITS = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic                                  i_keep,
    input  logic [15:0]                           i_stamp_x,
    input  logic [15:0]                           i_stamp_y,
    input  logic [FRAC_BITS-1:0]                  i_fx,
    input  logic [FRAC_BITS-1:0]                  i_fy,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic                                  o_keep,
    output logic [15:0]                           o_stamp_x,
    output logic [15:0]                           o_stamp_y,
    output logic [FRAC_BITS-1:0]                  o_fx,
    output logic [2:0][3:0][FRAC_BITS+7:0]        o_vsum
);
    import sps_pkg::*;

    localparam int VW = FRAC_BITS + 8;
    localparam logic [FRAC_BITS:0] SCALE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

    logic                       r_valid;
    logic                       r_keep;
    logic [15:0]                r_stamp_x;
    logic [15:0]                r_stamp_y;
    logic [FRAC_BITS-1:0]       r_fx;
    logic [2:0][3:0][VW-1:0]    r_vsum;

    logic                       w_ready;
    logic [FRAC_BITS:0]         w_fy_inv;
    logic [2:0][3:0][VW-1:0]    n_vsum;

    assign w_ready  = !r_valid || !i_stall;
    assign o_stall  = !w_ready;
    assign w_fy_inv = SCALE - {1'b0, i_fy};

    // each entry is at most 255 * scale, so VW bits hold it
    always_comb begin
        for (int r = 0; r < STAMP_SIZE; r++) begin
            for (int c = 0; c < MASK_SIZE; c++) begin
                n_vsum[r][c] = VW'(PEN_MASK[r][c]) * VW'(i_fy)
                             + VW'(PEN_MASK[r+1][c]) * VW'(w_fy_inv);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready && i_valid) begin
            r_keep    <= i_keep;
            r_stamp_x <= i_stamp_x;
            r_stamp_y <= i_stamp_y;
            r_fx      <= i_fx;
            r_vsum    <= n_vsum;
        end
    end

    assign o_valid   = r_valid;
    assign o_keep    = r_keep;
    assign o_stamp_x = r_stamp_x;
    assign o_stamp_y = r_stamp_y;
    assign o_fx      = r_fx;
    assign o_vsum    = r_vsum;

endmodule

// File: sv/sps_hblend.sv
// third stage: horizontal blend, truncation and output word register
module sps_hblend #(
    parameter int FRAC_BITS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_keep,
    input  logic [15:0]                       i_stamp_x,
    input  logic [15:0]                       i_stamp_y,
    input  logic [FRAC_BITS-1:0]              i_fx,
    input  logic [2:0][3:0][FRAC_BITS+7:0]    i_vsum,
    output logic                              o_valid,
    input  logic                              i_stall,
    output sps_pkg::t_out_word                o_word
);
    import sps_pkg::*;

    localparam int AW = 2 * FRAC_BITS + 8;
    localparam logic [FRAC_BITS:0] SCALE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

    logic               r_valid;
    t_out_word          r_word;

    logic               w_ready;
    logic [FRAC_BITS:0] w_fx_inv;
    logic [2:0][2:0][7:0] w_wt;
    t_out_word          n_word;

    assign w_ready  = !r_valid || !i_stall;
    assign o_stall  = !w_ready;
    assign w_fx_inv = SCALE - {1'b0, i_fx};

    // acc never exceeds 255 * scale^2, so the top byte is the weight
    always_comb begin
        logic [AW-1:0] acc;
        acc = '0;
        for (int r = 0; r < STAMP_SIZE; r++) begin
            for (int c = 0; c < STAMP_SIZE; c++) begin
                acc = AW'(i_fx) * AW'(i_vsum[r][c])
                    + AW'(w_fx_inv) * AW'(i_vsum[r][c+1]);
                w_wt[r][c] = acc[2*FRAC_BITS +: 8];
            end
        end
    end

    // dropped stamp: every field but visible goes to zero
    always_comb begin
        n_word             = '0;
        n_word.visible     = i_keep;
        if (i_keep) begin
            n_word.stamp_x     = i_stamp_x;
            n_word.stamp_y     = i_stamp_y;
            n_word.weight_r0c0 = w_wt[0][0];
            n_word.weight_r0c1 = w_wt[0][1];
            n_word.weight_r0c2 = w_wt[0][2];
            n_word.weight_r1c0 = w_wt[1][0];
            n_word.weight_r1c1 = w_wt[1][1];
            n_word.weight_r1c2 = w_wt[1][2];
            n_word.weight_r2c0 = w_wt[2][0];
            n_word.weight_r2c1 = w_wt[2][1];
            n_word.weight_r2c2 = w_wt[2][2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready && i_valid) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// File: sv/subpixel_stamp_mask_shift_top.sv
// top level of the subpixel stamp mask shift block: config registers and stage chain
//
//  channel   direction  handshake            word
//  --------  ---------  -------------------  ---------------------------------------
//  pen in    input      i_valid / o_stall    i_word: pen_x, pen_y
//  stamp out output     o_valid / i_stall    o_word: visible, stamp_x/y, nine weights
//  config    input      i_cfg_we             i_cfg_idx, i_cfg_data
//
//  one pen word is taken every cycle that o_stall is low, then registered in turn by
//  the floor/clip stage, vertical blend stage and horizontal blend/output register;
//  each stage holds its word while the next one is full and stalled, so a stall
//  on the output backs up stage by stage and only stops input once all are full
//  reset is synchronous, active low; it empties all stages and loads the
//  default frame height and clip rectangle
module subpixel_stamp_mask_shift_top #(
    parameter int FRAC_BITS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  sps_pkg::t_in_word                   i_word,
    output logic                                o_valid,
    input  logic                                i_stall,
    output sps_pkg::t_out_word                  o_word,
    input  logic                                i_cfg_we,
    input  logic [sps_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [sps_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import sps_pkg::*;

    localparam int VW = FRAC_BITS + 8;

    // configuration registers
    t_cfg_regs r_cfg;

    // front -> vertical blend
    logic                    w_s1_valid;
    logic                    w_s1_stall;
    logic                    w_s1_keep;
    logic [15:0]             w_s1_stamp_x;
    logic [15:0]             w_s1_stamp_y;
    logic [FRAC_BITS-1:0]    w_s1_fx;
    logic [FRAC_BITS-1:0]    w_s1_fy;

    // vertical blend -> horizontal blend
    logic                    w_s2_valid;
    logic                    w_s2_stall;
    logic                    w_s2_keep;
    logic [15:0]             w_s2_stamp_x;
    logic [15:0]             w_s2_stamp_y;
    logic [FRAC_BITS-1:0]    w_s2_fx;
    logic [2:0][3:0][VW-1:0] w_s2_vsum;

    // register writes, unknown index is ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_height <= RST_FRAME_HEIGHT;
            r_cfg.clip_left    <= RST_CLIP_LEFT;
            r_cfg.clip_top     <= RST_CLIP_TOP;
            r_cfg.clip_right   <= RST_CLIP_RIGHT;
            r_cfg.clip_bottom  <= RST_CLIP_BOTTOM;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FRAME_HEIGHT: begin
                    r_cfg.frame_height <= i_cfg_data[11:0];
                end
                CFG_CLIP_LEFT: begin
                    r_cfg.clip_left <= i_cfg_data;
                end
                CFG_CLIP_TOP: begin
                    r_cfg.clip_top <= i_cfg_data;
                end
                CFG_CLIP_RIGHT: begin
                    r_cfg.clip_right <= i_cfg_data;
                end
                CFG_CLIP_BOTTOM: begin
                    r_cfg.clip_bottom <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // stage 1: integer/fraction split and visibility decision
    sps_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_word    (i_word),
        .i_cfg     (r_cfg),
        .o_valid   (w_s1_valid),
        .i_stall   (w_s1_stall),
        .o_keep    (w_s1_keep),
        .o_stamp_x (w_s1_stamp_x),
        .o_stamp_y (w_s1_stamp_y),
        .o_fx      (w_s1_fx),
        .o_fy      (w_s1_fy)
    );

    // stage 2: mask rows blended by the row fraction
    sps_vblend #(
        .FRAC_BITS (FRAC_BITS)
    ) u_vblend (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_s1_valid),
        .o_stall   (w_s1_stall),
        .i_keep    (w_s1_keep),
        .i_stamp_x (w_s1_stamp_x),
        .i_stamp_y (w_s1_stamp_y),
        .i_fx      (w_s1_fx),
        .i_fy      (w_s1_fy),
        .o_valid   (w_s2_valid),
        .i_stall   (w_s2_stall),
        .o_keep    (w_s2_keep),
        .o_stamp_x (w_s2_stamp_x),
        .o_stamp_y (w_s2_stamp_y),
        .o_fx      (w_s2_fx),
        .o_vsum    (w_s2_vsum)
    );

    // stage 3: columns blended by the column fraction, output register
    sps_hblend #(
        .FRAC_BITS (FRAC_BITS)
    ) u_hblend (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_s2_valid),
        .o_stall   (w_s2_stall),
        .i_keep    (w_s2_keep),
        .i_stamp_x (w_s2_stamp_x),
        .i_stamp_y (w_s2_stamp_y),
        .i_fx      (w_s2_fx),
        .i_vsum    (w_s2_vsum),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_word    (o_word)
    );

    // a dropped stamp carries no origin and no weights
    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_word.visible) |->
            (o_word.stamp_x == '0) && (o_word.stamp_y == '0) &&
            (o_word.weight_r0c0 == '0) && (o_word.weight_r1c1 == '0) &&
            (o_word.weight_r2c2 == '0))
        else $error("dropped stamp with nonzero fields");

    // reset empties the output stage
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output word valid after reset");

    // with the output stage empty every stage can move, so input is never held
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled while output stage empty");

    // back pressure reaches the input only through full stages
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (w_s1_valid && w_s2_valid && o_valid && i_stall))
        else $error("input stalled with a bubble in the pipeline");

endmodule

// File: tb/stamp_checker.sv
// stamp checker: predicts each stamp word from the pen words taken in and checks the output
module stamp_checker #(
    parameter int FRAC_BITS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_pen_valid,
    input  logic                           i_pen_stall,
    input  sps_pkg::t_in_word              i_pen_word,
    input  logic                           i_stamp_valid,
    input  logic                           i_stamp_stall,
    input  sps_pkg::t_out_word             i_stamp_word,
    input  logic                           i_cfg_we,
    input  logic [sps_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sps_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import sps_pkg::*;

    localparam longint SCALE = longint'(1) << FRAC_BITS;

    typedef logic [0:8][7:0] t_weights;

    logic [11:0]        frame_h;
    logic signed [15:0] clip_l;
    logic signed [15:0] clip_t;
    logic signed [15:0] clip_r;
    logic signed [15:0] clip_b;

    t_out_word stamp_queue[$];
    int        fail_count = 0;
    int        word_count = 0;
    int        pending    = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;

    task automatic flag_mismatch(input string what);
        $display("mismatch: %s", what);
        fail_count++;
    endtask

    function automatic t_weights weights_of(input t_out_word w);
        return {w.weight_r0c0, w.weight_r0c1, w.weight_r0c2,
                w.weight_r1c0, w.weight_r1c1, w.weight_r1c2,
                w.weight_r2c0, w.weight_r2c1, w.weight_r2c2};
    endfunction

    function automatic t_out_word predict_stamp(input t_in_word pen);
        t_out_word res;
        t_weights  wts;
        longint    x, y, fx, fy, px, py, lsum, rsum, acc;
        bit        keep;
        int        r, c;
        x    = longint'(pen.pen_x);
        y    = longint'(pen.pen_y);
        fx   = x & (SCALE - 1);
        fy   = y & (SCALE - 1);
        px   = (x - fx) / SCALE;
        py   = (y - fy) / SCALE;
        keep = 1'b1;
        // rows more than a stamp outside the frame
        if (y < -STAMP_SIZE * SCALE || y > (longint'(frame_h) + STAMP_SIZE) * SCALE) begin
            keep = 1'b0;
        end
        if (clip_l > clip_r || clip_t > clip_b) begin
            keep = 1'b0;
        end
        // box of the stamp against the clip rectangle, on full floor values
        if (px > clip_r || px + STAMP_SIZE - 1 < clip_l ||
            py > clip_b || py + STAMP_SIZE - 1 < clip_t) begin
            keep = 1'b0;
        end
        res = '0;
        if (keep) begin
            res.visible = 1'b1;
            res.stamp_x = px[15:0];
            res.stamp_y = py[15:0];
            for (r = 0; r < STAMP_SIZE; r++) begin
                for (c = 0; c < STAMP_SIZE; c++) begin
                    lsum = longint'(PEN_MASK[r][c]) * fy +
                           longint'(PEN_MASK[r+1][c]) * (SCALE - fy);
                    rsum = longint'(PEN_MASK[r][c+1]) * fy +
                           longint'(PEN_MASK[r+1][c+1]) * (SCALE - fy);
                    acc  = fx * lsum + (SCALE - fx) * rsum;
                    wts[r*STAMP_SIZE+c] = 8'(acc >> (2 * FRAC_BITS));
                end
            end
            {res.weight_r0c0, res.weight_r0c1, res.weight_r0c2,
             res.weight_r1c0, res.weight_r1c1, res.weight_r1c2,
             res.weight_r2c0, res.weight_r2c1, res.weight_r2c2} = wts;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_word want;
        t_weights  want_wt, got_wt;
        int        k;
        if (!i_rst_n) begin
            frame_h = RST_FRAME_HEIGHT;
            clip_l  = RST_CLIP_LEFT;
            clip_t  = RST_CLIP_TOP;
            clip_r  = RST_CLIP_RIGHT;
            clip_b  = RST_CLIP_BOTTOM;
            stamp_queue.delete();
        end else begin
            if (i_stamp_valid && !i_stamp_stall) begin
                if (stamp_queue.size() == 0) begin
                    flag_mismatch($sformatf("stamp word %0d with nothing expected", word_count));
                end else begin
                    want    = stamp_queue.pop_front();
                    want_wt = weights_of(want);
                    got_wt  = weights_of(i_stamp_word);
                    if (i_stamp_word.visible !== want.visible) begin
                        flag_mismatch($sformatf("stamp word %0d visible expected %0h got %0h",
                            word_count, want.visible, i_stamp_word.visible));
                    end
                    if (i_stamp_word.stamp_x !== want.stamp_x) begin
                        flag_mismatch($sformatf("stamp word %0d stamp_x expected %0h got %0h",
                            word_count, want.stamp_x, i_stamp_word.stamp_x));
                    end
                    if (i_stamp_word.stamp_y !== want.stamp_y) begin
                        flag_mismatch($sformatf("stamp word %0d stamp_y expected %0h got %0h",
                            word_count, want.stamp_y, i_stamp_word.stamp_y));
                    end
                    for (k = 0; k < STAMP_SIZE * STAMP_SIZE; k++) begin
                        if (got_wt[k] !== want_wt[k]) begin
                            flag_mismatch($sformatf(
                                "stamp word %0d weight_r%0dc%0d expected %0h got %0h",
                                word_count, k / STAMP_SIZE, k % STAMP_SIZE,
                                want_wt[k], got_wt[k]));
                        end
                    end
                end
                word_count++;
            end
            if (i_pen_valid && !i_pen_stall) begin
                stamp_queue.push_back(predict_stamp(i_pen_word));
            end
            // register write lands after this edge's prediction
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FRAME_HEIGHT: frame_h = i_cfg_data[11:0];
                    CFG_CLIP_LEFT:    clip_l  = i_cfg_data;
                    CFG_CLIP_TOP:     clip_t  = i_cfg_data;
                    CFG_CLIP_RIGHT:   clip_r  = i_cfg_data;
                    CFG_CLIP_BOTTOM:  clip_b  = i_cfg_data;
                    default: ;
                endcase
            end
        end
        pending = stamp_queue.size();
    end

endmodule

// File: tb/testbench.sv
// testbench top for the subpixel stamp block: clock, reset, pen and register stimulus, verdict
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import sps_pkg::*;

    localparam int     FRAC_BITS      = 8;
    localparam longint SCALE          = longint'(1) << FRAC_BITS;
    localparam int     IDLE_PCT       = 8;
    localparam int     RESET_CYCLES   = 12;
    // three stages in the block, plus some margin
    localparam int     DRAIN_CYCLES   = 6;
    localparam int     WATCHDOG_LIMIT = 2000;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX = '1;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_valid    = 1'b0;
    logic                  o_stall;
    t_in_word              i_word     = '0;
    logic                  o_valid;
    logic                  i_stall    = 1'b0;
    t_out_word             o_word;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int fail_count;
    int pending;
    int stuck_cycles = 0;
    // when set, neither side idles
    bit quiet = 1'b0;

    // register values last written, used only to aim the random pens
    longint cur_fh = RST_FRAME_HEIGHT;
    longint cur_l  = RST_CLIP_LEFT;
    longint cur_t  = RST_CLIP_TOP;
    longint cur_r  = RST_CLIP_RIGHT;
    longint cur_b  = RST_CLIP_BOTTOM;

    always #10 i_clk = ~i_clk;

    subpixel_stamp_mask_shift_top #(
        .FRAC_BITS(FRAC_BITS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_word     (i_word),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_word     (o_word),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    stamp_checker #(
        .FRAC_BITS(FRAC_BITS)
    ) stamp_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pen_valid   (i_valid),
        .i_pen_stall   (o_stall),
        .i_pen_word    (i_word),
        .i_stamp_valid (o_valid),
        .i_stamp_stall (i_stall),
        .i_stamp_word  (o_word),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // output side stalls at random, IDLE_PCT percent of the time unless quiet is set
    always @(posedge i_clk) begin
        i_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
    end

    // watchdog: too many cycles with no word moving on either channel
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", stuck_cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // one pen word; valid may first drop at random, then holds until taken
    task automatic send_pen(input longint x, input longint y);
        if (!quiet && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_word  <= t_in_word'{pen_x: x[23:0], pen_y: y[23:0]};
        do @(posedge i_clk); while (o_stall);
    endtask

    // stop sending and wait until every expected stamp word is back and the pipe is empty
    task automatic drain_stamps();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // all five registers back to back, then one write to an index with no register
    task automatic program_regs(input logic [15:0] fh, input logic [15:0] l,
                                input logic [15:0] t, input logic [15:0] r,
                                input logic [15:0] b);
        logic [15:0]          vals [5];
        logic [CFG_IDX_W-1:0] idxs [5];
        int                   k;
        vals = '{fh, l, t, r, b};
        idxs = '{CFG_FRAME_HEIGHT, CFG_CLIP_LEFT, CFG_CLIP_TOP, CFG_CLIP_RIGHT,
                 CFG_CLIP_BOTTOM};
        for (k = 0; k < 5; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idxs[k];
            i_cfg_data <= vals[k];
            @(posedge i_clk);
        end
        // unused index: must leave every register alone
        i_cfg_idx  <= CFG_IDX_W'($urandom_range(CFG_IDX_MAX, CFG_CLIP_BOTTOM + 1));
        i_cfg_data <= CFG_DATA_W'($urandom());
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        cur_fh = longint'(fh[11:0]);
        cur_l  = longint'(signed'(l));
        cur_t  = longint'(signed'(t));
        cur_r  = longint'(signed'(r));
        cur_b  = longint'(signed'(b));
    endtask

    // pixel a few steps around a range, kept where a 24-bit pen can reach
    function automatic longint near_pix(input longint lo, input longint hi);
        longint a, b;
        a = (lo < hi ? lo : hi) - 4;
        b = (lo < hi ? hi : lo) + 4;
        if (a < -32768) a = -32768;
        if (b > 32767) b = 32767;
        if (a > b) a = b;
        return a + longint'($urandom_range(32'(b - a)));
    endfunction

    // pixel to fixed point, fraction often at its ends
    function automatic longint to_fixed(input longint pix);
        longint f;
        case ($urandom_range(3))
            0:       f = 0;
            1:       f = SCALE - 1;
            default: f = longint'($urandom_range(32'(SCALE - 1)));
        endcase
        return pix * SCALE + f;
    endfunction

    // mostly pens aimed at the clip box and the frame edges, some fully random
    task automatic run_random(input int n);
        longint x, y, row;
        int     k, m;
        for (k = 0; k < n; k++) begin
            m = $urandom_range(99);
            x = to_fixed(near_pix(cur_l, cur_r));
            if (m < 45) begin
                y = to_fixed(near_pix(cur_t, cur_b));
            end else if (m < 70) begin
                y = to_fixed(near_pix(-STAMP_SIZE, cur_fh + STAMP_SIZE));
            end else if (m < 85) begin
                // rows right at the vertical drop limits
                row = $urandom_range(1) ? -STAMP_SIZE : cur_fh + STAMP_SIZE;
                y   = to_fixed(row - 1 + longint'($urandom_range(2)));
            end else begin
                x = longint'($urandom());
                y = longint'($urandom());
            end
            send_pen(x, y);
        end
    endtask

    initial begin
        longint lv, tv;
        int     rep;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset registers: origin, fraction ends, negative floor, clip edges
        send_pen(0, 0);
        send_pen(SCALE - 1, SCALE - 1);
        send_pen(SCALE / 2, SCALE / 2 - 1);
        send_pen(-1, -1);
        send_pen(-3 * SCALE, 10 * SCALE);
        send_pen(-2 * SCALE, 10 * SCALE);
        send_pen(319 * SCALE + SCALE - 1, 239 * SCALE + SCALE - 1);
        send_pen(320 * SCALE, 0);
        send_pen(0, 243 * SCALE);
        run_random(140);

        // widest clip box, tallest frame: vertical limits and field extremes
        drain_stamps();
        program_regs(16'h0FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
        send_pen(0, -3 * SCALE);
        send_pen(0, -3 * SCALE - 1);
        send_pen(0, 4098 * SCALE);
        send_pen(0, 4098 * SCALE + 1);
        send_pen(-8388608, 0);
        send_pen(8388607, 0);
        send_pen(0, -8388608);
        send_pen(0, 8388607);
        // long stretch with no idling on either side
        quiet = 1'b1;
        run_random(140);
        quiet = 1'b0;

        // zero frame height, upper data bits set; small box around the origin
        drain_stamps();
        program_regs(16'hF000, 16'hFFFE, 16'hFFFB, 16'd3, 16'd4);
        send_pen(0, 3 * SCALE);
        send_pen(0, 3 * SCALE + 1);
        send_pen(0, -3 * SCALE);
        run_random(140);

        // empty box, left past right
        drain_stamps();
        program_regs(16'd240, 16'd10, 16'd0, 16'd9, 16'd239);
        send_pen(9 * SCALE, 5 * SCALE);
        send_pen(10 * SCALE, 5 * SCALE);
        run_random(110);

        // empty box, top past bottom
        drain_stamps();
        program_regs(16'd240, 16'd0, 16'd10, 16'd319, 16'd9);
        send_pen(5 * SCALE, 9 * SCALE);
        run_random(110);

        // one column at the most negative edge
        drain_stamps();
        program_regs(16'h0FFF, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF);
        send_pen(-8388608, 0);
        run_random(140);

        // random settings, the last one with fully random register data
        for (rep = 0; rep < 3; rep++) begin
            drain_stamps();
            if (rep < 2) begin
                lv = longint'($urandom_range(800)) - 400;
                tv = longint'($urandom_range(800)) - 400;
                program_regs(16'($urandom()), 16'(lv), 16'(tv),
                             16'(lv - 20 + longint'($urandom_range(620))),
                             16'(tv - 20 + longint'($urandom_range(620))));
            end else begin
                program_regs(16'($urandom()), 16'($urandom()), 16'($urandom()),
                             16'($urandom()), 16'($urandom()));
            end
            run_random(100);
        end

        drain_stamps();
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
